// File: rtl/core/plob_pkg.sv
// Package for the price-level order book: field widths, status codes,
// level record type and parameter defaults. No dependencies.
`timescale 1ns / 1ps

package plob_pkg;

  localparam int PRICE_W  = 48;
  localparam int QTY_W    = 48;
  localparam int SYM_IN_W = 3;
  localparam int STATUS_W = 2;

  localparam int NUM_SYMBOLS_DEF     = 8;
  localparam int LEVELS_PER_SIDE_DEF = 16;

  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_APPLIED = 2'd0,
    STATUS_ABSENT  = 2'd1,
    STATUS_FULL    = 2'd2
  } status_t;

  // One stored price level; used = 0 marks a free slot.
  typedef struct packed {
    logic             used;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } level_t;

endpackage

// File: rtl/core/plob_if.sv
// Valid/ready channel interfaces for the order book: update requests in,
// best-price answers out. Depends on plob_pkg.
`timescale 1ns / 1ps

interface plob_order_if import plob_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SYM_IN_W-1:0] symbol_index;
  logic                side;
  logic [PRICE_W-1:0]  price;
  logic [QTY_W-1:0]    quantity;

  modport source (output valid, symbol_index, side, price, quantity, input ready);
  modport sink (input valid, symbol_index, side, price, quantity, output ready);
endinterface

interface plob_book_if import plob_pkg::*; ();
  logic               valid;
  logic               ready;
  status_t            status;
  logic               best_bid_valid;
  logic [PRICE_W-1:0] best_bid_price;
  logic [QTY_W-1:0]   best_bid_quantity;
  logic               best_ask_valid;
  logic [PRICE_W-1:0] best_ask_price;
  logic [QTY_W-1:0]   best_ask_quantity;

  modport source (output valid, status, best_bid_valid, best_bid_price, best_bid_quantity,
                  best_ask_valid, best_ask_price, best_ask_quantity, input ready);
  modport sink (input valid, status, best_bid_valid, best_bid_price, best_bid_quantity,
                best_ask_valid, best_ask_price, best_ask_quantity, output ready);
endinterface

// File: rtl/core/plob_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module plob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/price_level_order_book.sv
// Top level of the price-level order book: sequencer, shared scan and compare
// logic, one level memory per side. Depends on plob_pkg, plob_if, plob_ram.
`timescale 1ns / 1ps

// Channel   Direction  Transaction
// order     in         symbol_index, side, price, quantity: one book update
// book      out        status and best bid / best ask of the updated symbol
//
// An update is accepted in the idle state, scans the symbol's slots in the
// scan state and commits in the commit state, after which the block returns
// to idle; it takes no new update before the last one has committed. The
// scan reads one level slot of the symbol per cycle from both side memories
// through their single read ports. After reset a clearing pass writes every
// memory entry to an empty level, and no update is accepted until it is done.
// A stalled result stays in the output register; the next update may be
// accepted and scanned meanwhile, and waits in its commit step until the
// output register frees up.

module price_level_order_book import plob_pkg::*; #(
  parameter int NUM_SYMBOLS     = NUM_SYMBOLS_DEF,
  parameter int LEVELS_PER_SIDE = LEVELS_PER_SIDE_DEF
) (
  input logic         clk,
  input logic         rst,
  plob_order_if.sink  order,
  plob_book_if.source book
);

  localparam int DEPTH  = NUM_SYMBOLS * LEVELS_PER_SIDE;
  localparam int AW     = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int SYM_W  = NUM_SYMBOLS > 1 ? $clog2(NUM_SYMBOLS) : 1;
  localparam int CNT_W  = $clog2(LEVELS_PER_SIDE + 1);
  localparam int SLOT_W = LEVELS_PER_SIDE > 1 ? $clog2(LEVELS_PER_SIDE) : 1;

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t state;

  // Request registers captured at acceptance.
  logic [AW-1:0]      base_addr;
  logic               req_side;
  logic [PRICE_W-1:0] req_price;
  logic [QTY_W-1:0]   req_qty;

  // Scan bookkeeping: slot counter, match and free-slot search, running bests.
  logic [CNT_W-1:0]   cnt;
  logic [AW-1:0]      clr_addr;
  logic               hit_found;
  logic [SLOT_W-1:0]  hit_slot;
  logic               free_found;
  logic [SLOT_W-1:0]  free_slot;
  logic               bid_valid;
  logic [PRICE_W-1:0] bid_price;
  logic [QTY_W-1:0]   bid_qty;
  logic               ask_valid;
  logic [PRICE_W-1:0] ask_price;
  logic [QTY_W-1:0]   ask_qty;

  // Output register.
  logic               out_valid;
  status_t            out_status;
  logic               out_bid_valid;
  logic [PRICE_W-1:0] out_bid_price;
  logic [QTY_W-1:0]   out_bid_qty;
  logic               out_ask_valid;
  logic [PRICE_W-1:0] out_ask_price;
  logic [QTY_W-1:0]   out_ask_qty;

  // Memory ports.
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  level_t             wdata;
  logic               bid_we;
  logic               ask_we;
  logic [$bits(level_t)-1:0] bid_rdata;
  logic [$bits(level_t)-1:0] ask_rdata;
  level_t             rd_bid;
  level_t             rd_ask;

  logic               accept;
  logic [SYM_W-1:0]   sym_mod;
  logic [SLOT_W-1:0]  cur_slot;
  logic               scan_data;
  level_t             upd_lvl;
  logic               match;
  logic               bid_take;
  logic               ask_take;

  logic               commit_fire;
  status_t            cm_status;
  logic               cm_write;
  logic [SLOT_W-1:0]  cm_slot;
  level_t             cm_level;
  logic               cm_add;

  assign order.ready = (state == S_IDLE);
  assign accept      = order.valid && order.ready;

  // The symbol index is three bits wide, so the wrap into range is a tiny table.
  always_comb begin
    sym_mod = '0;
    for (int k = 0; k < (1 << SYM_IN_W); k++) begin
      if (order.symbol_index == SYM_IN_W'(k)) begin
        sym_mod = SYM_W'(k % NUM_SYMBOLS);
      end
    end
  end

  plob_ram #(.WIDTH($bits(level_t)), .DEPTH(DEPTH)) u_bid_ram (
    .clk   (clk),
    .we    (bid_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (bid_rdata)
  );

  plob_ram #(.WIDTH($bits(level_t)), .DEPTH(DEPTH)) u_ask_ram (
    .clk   (clk),
    .we    (ask_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ask_rdata)
  );

  assign rd_bid = level_t'(bid_rdata);
  assign rd_ask = level_t'(ask_rdata);

  // Both memories are read at the same slot of the symbol, so the bid and ask
  // bests are gathered in one pass while the updated side is searched.
  assign raddr = base_addr + AW'(cnt);

  // Read data of slot cnt-1 is present whenever the counter has moved past zero.
  assign scan_data = (state == S_SCAN) && (cnt != '0);
  assign cur_slot  = SLOT_W'(cnt - CNT_W'(1));
  assign upd_lvl   = (req_side == SIDE_ASK) ? rd_ask : rd_bid;
  assign match     = upd_lvl.used && (upd_lvl.price == req_price);

  // Prices on one side are unique, so leaving out the matching level here and
  // folding in the updated level at commit gives the post-update best.
  assign bid_take = rd_bid.used && !(req_side == SIDE_BID && match) &&
                    (!bid_valid || rd_bid.price > bid_price);
  assign ask_take = rd_ask.used && !(req_side == SIDE_ASK && match) &&
                    (!ask_valid || rd_ask.price < ask_price);

  // Commit decision: removal, overwrite, insertion into the lowest free slot,
  // a drop when the side is full, or an absent status when a removal misses.
  always_comb begin
    cm_status = STATUS_APPLIED;
    cm_write  = 1'b0;
    cm_slot   = hit_slot;
    cm_level  = '0;
    cm_add    = 1'b0;
    if (req_qty == '0) begin
      if (hit_found) begin
        cm_write = 1'b1;
      end else begin
        cm_status = STATUS_ABSENT;
      end
    end else begin
      cm_level = '{used: 1'b1, price: req_price, qty: req_qty};
      if (hit_found) begin
        cm_write = 1'b1;
        cm_add   = 1'b1;
      end else if (free_found) begin
        cm_write = 1'b1;
        cm_add   = 1'b1;
        cm_slot  = free_slot;
      end else begin
        cm_status = STATUS_FULL;
      end
    end
  end

  assign commit_fire = (state == S_COMMIT) && (!out_valid || book.ready);

  // The write port serves the clearing pass and the commit step.
  always_comb begin
    bid_we = 1'b0;
    ask_we = 1'b0;
    waddr  = base_addr + AW'(cm_slot);
    wdata  = cm_level;
    if (state == S_CLEAR) begin
      bid_we = 1'b1;
      ask_we = 1'b1;
      waddr  = clr_addr;
      wdata  = '0;
    end else if (commit_fire && cm_write) begin
      bid_we = (req_side == SIDE_BID);
      ask_we = (req_side == SIDE_ASK);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      cnt      <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          cnt <= '0;
          if (accept) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(LEVELS_PER_SIDE)) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (commit_fire) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  // Request capture and scan datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      base_addr  <= AW'(sym_mod) * AW'(LEVELS_PER_SIDE);
      req_side   <= order.side;
      req_price  <= order.price;
      req_qty    <= order.quantity;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      bid_valid  <= 1'b0;
      bid_price  <= '0;
      bid_qty    <= '0;
      ask_valid  <= 1'b0;
      ask_price  <= '0;
      ask_qty    <= '0;
    end else if (scan_data) begin
      if (match && !hit_found) begin
        hit_found <= 1'b1;
        hit_slot  <= cur_slot;
      end
      if (!upd_lvl.used && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= cur_slot;
      end
      if (bid_take) begin
        bid_valid <= 1'b1;
        bid_price <= rd_bid.price;
        bid_qty   <= rd_bid.qty;
      end
      if (ask_take) begin
        ask_valid <= 1'b1;
        ask_price <= rd_ask.price;
        ask_qty   <= rd_ask.qty;
      end
    end
  end

  // Output register: loaded at commit with the running bests, the updated
  // level folded into its own side.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit_fire) begin
      out_valid <= 1'b1;
    end else if (book.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_fire) begin
      out_status    <= cm_status;
      out_bid_valid <= bid_valid;
      out_bid_price <= bid_price;
      out_bid_qty   <= bid_qty;
      out_ask_valid <= ask_valid;
      out_ask_price <= ask_price;
      out_ask_qty   <= ask_qty;
      if (cm_add && req_side == SIDE_BID && (!bid_valid || req_price > bid_price)) begin
        out_bid_valid <= 1'b1;
        out_bid_price <= req_price;
        out_bid_qty   <= req_qty;
      end
      if (cm_add && req_side == SIDE_ASK && (!ask_valid || req_price < ask_price)) begin
        out_ask_valid <= 1'b1;
        out_ask_price <= req_price;
        out_ask_qty   <= req_qty;
      end
    end
  end

  assign book.valid             = out_valid;
  assign book.status            = out_status;
  assign book.best_bid_valid    = out_bid_valid;
  assign book.best_bid_price    = out_bid_price;
  assign book.best_bid_quantity = out_bid_qty;
  assign book.best_ask_valid    = out_ask_valid;
  assign book.best_ask_price    = out_ask_price;
  assign book.best_ask_quantity = out_ask_qty;

endmodule

// File: bench/plob_quote_checker.sv
// Checker for the price-level order book: watches the order and book channels,
// keeps its own copy of every symbol's levels and compares each quote.
// Depends on plob_pkg and plob_if.
`timescale 1ns / 1ps

module plob_quote_checker import plob_pkg::*; #(
  parameter int NUM_SYMBOLS     = NUM_SYMBOLS_DEF,
  parameter int LEVELS_PER_SIDE = LEVELS_PER_SIDE_DEF
) (
  input  logic  clk,
  input  logic  rst,
  plob_order_if order,
  plob_book_if  book,
  output int    mismatches,
  output int    outstanding
);

  typedef struct packed {
    status_t            status;
    logic               bid_valid;
    logic [PRICE_W-1:0] bid_price;
    logic [QTY_W-1:0]   bid_qty;
    logic               ask_valid;
    logic [PRICE_W-1:0] ask_price;
    logic [QTY_W-1:0]   ask_qty;
  } book_quote_t;

  // Level tables indexed by side (bid 0, ask 1), symbol and slot.
  logic [PRICE_W-1:0] lvl_price [2][NUM_SYMBOLS][LEVELS_PER_SIDE];
  logic [QTY_W-1:0]   lvl_qty   [2][NUM_SYMBOLS][LEVELS_PER_SIDE];
  logic               lvl_used  [2][NUM_SYMBOLS][LEVELS_PER_SIDE];

  book_quote_t expected_quotes [$];

  function automatic status_t apply_level_update(int sym, logic sd,
                                                 logic [PRICE_W-1:0] prc,
                                                 logic [QTY_W-1:0] qty);
    int hit;
    int free_slot;
    hit       = -1;
    free_slot = -1;
    for (int i = 0; i < LEVELS_PER_SIDE; i++) begin
      if (lvl_used[sd][sym][i]) begin
        if (lvl_price[sd][sym][i] == prc && hit < 0) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (qty == '0) begin
      if (hit < 0) return STATUS_ABSENT;
      lvl_used[sd][sym][hit]  = 1'b0;
      lvl_price[sd][sym][hit] = '0;
      lvl_qty[sd][sym][hit]   = '0;
      return STATUS_APPLIED;
    end
    if (hit >= 0) begin
      lvl_qty[sd][sym][hit] = qty;
      return STATUS_APPLIED;
    end
    if (free_slot < 0) return STATUS_FULL;
    lvl_used[sd][sym][free_slot]  = 1'b1;
    lvl_price[sd][sym][free_slot] = prc;
    lvl_qty[sd][sym][free_slot]   = qty;
    return STATUS_APPLIED;
  endfunction

  // Highest bid and lowest ask of one symbol; the first slot wins a tie.
  function automatic book_quote_t quote_symbol(int sym);
    book_quote_t q;
    q = '0;
    for (int i = 0; i < LEVELS_PER_SIDE; i++) begin
      if (lvl_used[SIDE_BID][sym][i] &&
          (!q.bid_valid || lvl_price[SIDE_BID][sym][i] > q.bid_price)) begin
        q.bid_valid = 1'b1;
        q.bid_price = lvl_price[SIDE_BID][sym][i];
        q.bid_qty   = lvl_qty[SIDE_BID][sym][i];
      end
      if (lvl_used[SIDE_ASK][sym][i] &&
          (!q.ask_valid || lvl_price[SIDE_ASK][sym][i] < q.ask_price)) begin
        q.ask_valid = 1'b1;
        q.ask_price = lvl_price[SIDE_ASK][sym][i];
        q.ask_qty   = lvl_qty[SIDE_ASK][sym][i];
      end
    end
    return q;
  endfunction

  task automatic check_field(input string field, input logic [47:0] want,
                             input logic [47:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    book_quote_t want;
    status_t     st;
    int          sym;
    if (rst) begin
      foreach (lvl_used[s, y, i]) begin
        lvl_used[s][y][i]  = 1'b0;
        lvl_price[s][y][i] = '0;
        lvl_qty[s][y][i]   = '0;
      end
      expected_quotes.delete();
      mismatches = 0;
    end else begin
      if (book.valid && book.ready) begin
        if (expected_quotes.size() == 0) begin
          mismatches++;
          $display("%0t ns: quote transaction with none expected, status %h", $time,
                   book.status);
        end else begin
          want = expected_quotes.pop_front();
          check_field("status", 48'(want.status), 48'(book.status));
          check_field("best_bid_valid", 48'(want.bid_valid), 48'(book.best_bid_valid));
          check_field("best_bid_price", want.bid_price, book.best_bid_price);
          check_field("best_bid_quantity", want.bid_qty, book.best_bid_quantity);
          check_field("best_ask_valid", 48'(want.ask_valid), 48'(book.best_ask_valid));
          check_field("best_ask_price", want.ask_price, book.best_ask_price);
          check_field("best_ask_quantity", want.ask_qty, book.best_ask_quantity);
        end
      end
      if (order.valid && order.ready) begin
        sym  = int'(order.symbol_index) % NUM_SYMBOLS;
        st   = apply_level_update(sym, order.side, order.price, order.quantity);
        want = quote_symbol(sym);
        want.status = st;
        expected_quotes.push_back(want);
      end
    end
    outstanding = expected_quotes.size();
  end

endmodule

// File: bench/tb_price_level_order_book.sv
// Testbench top for the price-level order book: clock, reset, update stimulus,
// quote receiver with stalls, watchdog and verdict. Depends on plob_pkg,
// plob_if, price_level_order_book and plob_quote_checker.
`timescale 1ns / 1ps

module tb_price_level_order_book;
  import plob_pkg::*;

  localparam int NUM_SYM      = NUM_SYMBOLS_DEF;
  localparam int LEVELS       = LEVELS_PER_SIDE_DEF;
  localparam int RANDOM_ITEMS = 1250;
  // The receiver holds off once this many updates have gone in, so the block's
  // output and commit stages fill and the order channel backs up while the
  // sender keeps offering.
  localparam int HOLD_AT      = 150;
  localparam int HOLD_OFF     = 400;
  // The longest legitimate quiet spell is the hold-off plus one update time;
  // the clearing pass after reset is far shorter.
  localparam int STALL_LIMIT  = 5000;
  localparam int IDLE_PCT     = 6;
  localparam logic [PRICE_W-1:0] PRICE_MAX = '1;
  localparam logic [QTY_W-1:0]   QTY_MAX   = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  plob_order_if order ();
  plob_book_if  book ();

  int mismatches;
  int outstanding;
  int orders_accepted = 0;
  int watchdog_cycles = 0;
  // Set by the stimulus for a stretch of the random part in which neither
  // side idles, so back-to-back transactions are seen as well.
  bit no_idle_stretch = 1'b0;

  price_level_order_book #(
    .NUM_SYMBOLS    (NUM_SYM),
    .LEVELS_PER_SIDE(LEVELS)
  ) i_dut (
    .clk  (clk),
    .rst  (rst),
    .order(order),
    .book (book)
  );

  plob_quote_checker #(
    .NUM_SYMBOLS    (NUM_SYM),
    .LEVELS_PER_SIDE(LEVELS)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .order      (order),
    .book       (book),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: any accepted transaction on either channel restarts the count.
  always @(posedge clk) begin
    if ((order.valid && order.ready) || (book.valid && book.ready)) begin
      watchdog_cycles <= 0;
    end else begin
      watchdog_cycles <= watchdog_cycles + 1;
      if (watchdog_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  // Offers one update transaction. It is entered and left at a falling edge,
  // and valid stays high on leaving so the next update follows without a gap
  // unless the random idling inserts one.
  task automatic offer_update(input logic [SYM_IN_W-1:0] sym, input logic sd,
                              input logic [PRICE_W-1:0] prc,
                              input logic [QTY_W-1:0] qty);
    while (!no_idle_stretch && $urandom_range(99) < IDLE_PCT) begin
      order.valid <= 1'b0;
      @(negedge clk);
    end
    order.valid        <= 1'b1;
    order.symbol_index <= sym;
    order.side         <= sd;
    order.price        <= prc;
    order.quantity     <= qty;
    do @(posedge clk); while (!order.ready);
    orders_accepted++;
    @(negedge clk);
  endtask

  // Quote receiver: random stalls, one long hold-off, then random stalls
  // again except during the stretch without idling.
  initial begin : quote_receiver
    book.ready = 1'b0;
    wait (!rst);
    while (orders_accepted < HOLD_AT) begin
      @(negedge clk);
      book.ready <= no_idle_stretch || ($urandom_range(99) >= IDLE_PCT);
    end
    repeat (HOLD_OFF) begin
      @(negedge clk);
      book.ready <= 1'b0;
    end
    forever begin
      @(negedge clk);
      book.ready <= no_idle_stretch || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin : stimulus
    logic [PRICE_W-1:0]  pool_base [NUM_SYM];
    logic [SYM_IN_W-1:0] sym;
    logic                sd;
    logic [PRICE_W-1:0]  prc;
    logic [QTY_W-1:0]    qty;
    int                  remove_pct;

    order.valid        = 1'b0;
    order.symbol_index = '0;
    order.side         = SIDE_BID;
    order.price        = '0;
    order.quantity     = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Removals on an empty book come back absent with both
    // sides reported empty and zero.
    offer_update(3'd0, SIDE_BID, 48'h123, '0);
    // Extremes of price and quantity on symbol 7: best bid at the top price,
    // best ask at price zero, then a lower bid that must not take the lead.
    offer_update(3'd7, SIDE_BID, PRICE_MAX, QTY_MAX);
    offer_update(3'd7, SIDE_ASK, '0, 48'd1);
    offer_update(3'd7, SIDE_BID, '0, 48'd5);
    // Removing the best bid promotes the next bid level; the ask side
    // then goes empty by removing its only level.
    offer_update(3'd7, SIDE_BID, PRICE_MAX, '0);
    offer_update(3'd7, SIDE_ASK, '0, '0);
    // Fill the ask side of symbol 3, then a new price is dropped as full,
    // while an existing price is still overwritten on the full side.
    for (int i = 0; i < LEVELS; i++) begin
      offer_update(3'd3, SIDE_ASK, 48'd1000 + 48'(3 * i), 48'(i + 1));
    end
    offer_update(3'd3, SIDE_ASK, 48'd999, 48'd77);
    offer_update(3'd3, SIDE_ASK, 48'd1000, 48'd55);

    // Random part. Each symbol draws most prices from a pool of 24 keys, more
    // than a side can hold, so hits, fills, drops and removals all happen.
    // The share of removals rises over the run so the sides first fill up
    // and later drain to empty. About one update in ten is pure noise.
    foreach (pool_base[s]) pool_base[s] = rand48();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle_stretch = (n >= 600 && n < 850);
      remove_pct = (n < 400) ? 20 : (n < 800) ? 35 : 55;
      sym = 3'($urandom_range(NUM_SYM - 1));
      sd  = 1'($urandom_range(1));
      if ($urandom_range(99) < 10) begin
        prc = rand48();
        qty = ($urandom_range(1) == 0) ? '0 : rand48();
      end else begin
        case ($urandom_range(49))
          0:       prc = '0;
          1:       prc = PRICE_MAX;
          default: prc = pool_base[sym] + 48'($urandom_range(23));
        endcase
        if ($urandom_range(99) < remove_pct) begin
          qty = '0;
        end else if ($urandom_range(49) == 0) begin
          qty = QTY_MAX;
        end else begin
          qty = rand48();
          if (qty == '0) qty = 48'd1;
        end
      end
      offer_update(sym, sd, prc, qty);
    end
    no_idle_stretch = 1'b0;
    order.valid <= 1'b0;

    // Drain: every quote must arrive, then allow a few update times for any
    // stray transaction to show up.
    wait (outstanding == 0);
    repeat (4 * (LEVELS + 3)) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/plob_pkg.sv
rtl/core/plob_if.sv
rtl/core/plob_ram.sv
rtl/core/price_level_order_book.sv
bench/plob_quote_checker.sv
bench/tb_price_level_order_book.sv
